>>> sv/ppitp_pkg.sv
// ---------------------------------------------------------------------------
// ppitp_pkg: shared types and constants of the palette ink placer
// Beat payload types, configuration types and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package ppitp_pkg;

   // Command codes carried in the cmd field.
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_CANVAS_WIDTH      = 2'd0;
   localparam logic [1:0] CSR_CANVAS_HEIGHT     = 2'd1;
   localparam logic [1:0] CSR_TRANSPARENCY_ON   = 2'd2;
   localparam logic [1:0] CSR_TRANSPARENT_INDEX = 2'd3;

   // Register reset values.
   localparam logic [8:0] CANVAS_WIDTH_RESET  = 9'd128;
   localparam logic [8:0] CANVAS_HEIGHT_RESET = 9'd128;

   // The frame sits this many pixels above the bottom of the sprite.
   localparam int BOTTOM_MARGIN = 2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] color_index;
      logic [15:0] color_value;
      logic [7:0] run_x;
      logic [7:0] run_left;
      logic [7:0] run_top;
      logic [7:0] run_row;
      logic       last_in_row;
   } req_type;

   typedef struct packed {
      logic [10:0] byte_addr;
      logic [2:0]  bit_pos;
   } rsp_type;

   // Item handed from the front end to the back end: a placed pixel and
   // the palette colour it reads.
   typedef struct packed {
      rsp_type     place;
      logic [15:0] color;
   } mid_type;

   typedef struct packed {
      logic [8:0] canvas_width;
      logic [8:0] canvas_height;
      logic       transparency_on;
      logic [7:0] transparent_index;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/ppitp_ram.sv
// ---------------------------------------------------------------------------
// ppitp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ppitp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/ppitp_fifo.sv
// ---------------------------------------------------------------------------
// ppitp_fifo: small register queue
// Power-of-two depth, simultaneous push and pop, occupancy count.
// ---------------------------------------------------------------------------
`default_nettype none

module ppitp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [WIDTH-1:0]       push_data,
   input  wire logic                   pop,
   output logic      [WIDTH-1:0]       pop_data,
   output logic                        empty,
   output logic      [$clog2(DEPTH):0] count
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             full;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign count   = count_ff;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> sv/ppitp_front.sv
// ---------------------------------------------------------------------------
// ppitp_front: intake, palette and placement
// Accepts beats, writes the palette, places pixels and reads their colour.
// ---------------------------------------------------------------------------
`default_nettype none

module ppitp_front import ppitp_pkg::*; #(
   parameter int SPRITE_WIDTH  = 128,
   parameter int SPRITE_HEIGHT = 128,
   parameter int MID_DEPTH     = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfg_type                    cfg,
   input  wire logic                       req_push,
   input  wire req_type                    req_data,
   output logic                            req_full,
   input  wire logic [$clog2(MID_DEPTH):0] mid_count,
   output logic                            mid_push,
   output mid_type                         mid_data
);

   localparam int XW = $clog2(SPRITE_WIDTH);
   localparam int YW = $clog2(SPRITE_HEIGHT);
   localparam int CW = $clog2(MID_DEPTH) + 1;

   logic              accept;
   logic [8:0]        src_y;
   logic              src_ok, x_ok, y_ok, opaque, place_ok;
   logic signed [10:0] diff_x, diff_x_adj, x0, y0, dst_x, dst_y;
   logic              s1_valid_ff, s1_valid_in;
   logic [XW-1:0]     s1_dst_x_ff;
   logic [YW-1:0]     s1_dst_y_ff;
   logic [16:0]       bit_num;
   logic [15:0]       color;

   // Space is reserved for the pixel still waiting on its palette read.
   assign req_full = (mid_count + CW'(s1_valid_ff)) >= CW'(MID_DEPTH);
   assign accept   = req_push & ~req_full;

   ppitp_ram #(
      .WIDTH (16),
      .DEPTH (256)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && req_data.cmd == CMD_PALETTE_WRITE),
      .wr_addr (req_data.color_index),
      .wr_data (req_data.color_value),
      .rd_addr (req_data.color_index),
      .rd_data (color)
   );

   // Horizontal offset rounds toward zero, vertical offset leaves a margin.
   always_comb begin
      diff_x     = 11'(SPRITE_WIDTH) - 11'(cfg.canvas_width);
      diff_x_adj = diff_x + 11'(diff_x[10]);
      x0         = diff_x_adj >>> 1;
      y0         = 11'(SPRITE_HEIGHT) - 11'(cfg.canvas_height) - 11'(BOTTOM_MARGIN);
      src_y      = 9'(req_data.run_top) + 9'(req_data.run_row);
      src_ok     = src_y < cfg.canvas_height;
      dst_y      = 11'(src_y) + y0;
      dst_x      = 11'(req_data.run_x) + 11'(req_data.run_left) + x0;
      y_ok       = ~dst_y[10] && (dst_y[9:0] < 10'(SPRITE_HEIGHT));
      x_ok       = ~dst_x[10] && (dst_x[9:0] < 10'(SPRITE_WIDTH));
      opaque     = ~(cfg.transparency_on &&
                     req_data.color_index == cfg.transparent_index);
      place_ok   = src_ok && y_ok && x_ok && opaque;
      s1_valid_in = accept && req_data.cmd == CMD_PIXEL && place_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dst_x_ff <= dst_x[XW-1:0];
      s1_dst_y_ff <= dst_y[YW-1:0];
   end

   assign bit_num  = 17'(s1_dst_y_ff) * 17'(SPRITE_WIDTH) + 17'(s1_dst_x_ff);
   assign mid_push = s1_valid_ff;

   always_comb begin
      mid_data.place.byte_addr = bit_num[13:3];
      mid_data.place.bit_pos   = bit_num[2:0];
      mid_data.color           = color;
   end

endmodule

`default_nettype wire

>>> sv/ppitp_back.sv
// ---------------------------------------------------------------------------
// ppitp_back: ink classification and result queue
// Drops holes, queues the bit placement of ink pixels for the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module ppitp_back import ppitp_pkg::*; #(
   parameter int OUT_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    mid_empty,
   input  wire mid_type mid_data,
   output logic         mid_pop,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   localparam int DARK_MAX   = 32;
   localparam int LIGHT_MIN  = 220;
   localparam int CHROMA_MIN = 16;
   // An average of 40 to 220 under truncation is a channel sum of 120 to 662.
   localparam int SUM_LO     = 3 * 40;
   localparam int SUM_HI     = 3 * 220 + 2;
   localparam int OCW        = $clog2(OUT_DEPTH) + 1;

   logic [7:0] r, g, b, mx, mn;
   logic [9:0] sum;
   logic       ink, out_full, out_push;
   logic [OCW-1:0] out_count;

   always_comb begin
      r   = {mid_data.color[15:11], 3'b000};
      g   = {mid_data.color[10:5], 2'b00};
      b   = {mid_data.color[4:0], 3'b000};
      mx  = (r > g) ? r : g;
      mn  = (r < g) ? r : g;
      if (b > mx) begin
         mx = b;
      end
      if (b < mn) begin
         mn = b;
      end
      sum = 10'(r) + 10'(g) + 10'(b);
      if (mx < 8'(DARK_MAX)) begin
         ink = 1'b0;
      end else if (mn > 8'(LIGHT_MIN)) begin
         ink = 1'b0;
      end else if ((mx - mn) >= 8'(CHROMA_MIN)) begin
         ink = 1'b1;
      end else begin
         ink = (sum >= 10'(SUM_LO)) && (sum <= 10'(SUM_HI));
      end
   end

   assign out_full = (out_count == OCW'(OUT_DEPTH));
   assign out_push = ~mid_empty & ink & ~out_full;
   assign mid_pop  = ~mid_empty & (~ink | ~out_full);

   ppitp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (mid_data.place),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

endmodule

`default_nettype wire

>>> sv/palette_pixel_ink_threshold_placer.sv
// ---------------------------------------------------------------------------
// palette_pixel_ink_threshold_placer: palette pixel to sprite bit placer
// Turns palette-indexed pixels into the sprite bitmap bits they set.
// ---------------------------------------------------------------------------
// Usage. Beats enter on the req_ channel as a queue: a beat is taken at a
// rising edge with req_push high and req_full low. A palette-write beat
// (cmd 0) stores an RGB565 colour and produces nothing. A pixel beat (cmd 1)
// is placed in the sprite, with the canvas centered horizontally and raised
// two pixels above the bottom; if its row is inside the canvas, it lands
// inside the sprite, is not the transparent index and its colour counts as
// ink, one result beat appears on the rsp_ channel carrying the byte
// address and the bit to set. Results are read as a queue: the oldest one
// is on rsp_data while rsp_empty is low, and rsp_pop takes it.
// Throughput is one beat per cycle on both sides while req_full is low and
// the receiver pops each result as it appears. A taken pixel goes through
// these steps in order: its palette read and placement are registered, it
// moves into the queue between the halves, and it is then classified into
// the result queue, from which it can be popped.
// While the receiver stalls, results collect in a two-entry result queue and
// a four-entry queue between placement and classification; req_full rises
// once that queue and the pending palette read fill it.
// Reset empties both queues and restores the canvas registers to 128 x 128
// with transparency off. Palette contents are undefined until written.
// The csr_ port holds four 32-bit registers at byte offsets 0, 4, 8 and 12.
// ---------------------------------------------------------------------------
`default_nettype none

module palette_pixel_ink_threshold_placer import ppitp_pkg::*; #(
   parameter int SPRITE_WIDTH  = 128,
   parameter int SPRITE_HEIGHT = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   // Result channel.
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // The queue between the front end and the back end.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [1:0] csr_index;

   logic       mid_push, mid_pop, mid_empty;
   mid_type    mid_in_data, mid_out_data;
   logic [$clog2(MID_DEPTH):0] mid_count;

   // Configuration registers. The port never waits, and only the word
   // offset selects a register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:      cfg_in.canvas_width      = csr_pwdata[8:0];
            CSR_CANVAS_HEIGHT:     cfg_in.canvas_height     = csr_pwdata[8:0];
            CSR_TRANSPARENCY_ON:   cfg_in.transparency_on   = csr_pwdata[0];
            CSR_TRANSPARENT_INDEX: cfg_in.transparent_index = csr_pwdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width      <= CANVAS_WIDTH_RESET;
         cfg_ff.canvas_height     <= CANVAS_HEIGHT_RESET;
         cfg_ff.transparency_on   <= 1'b0;
         cfg_ff.transparent_index <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_index)
         CSR_CANVAS_WIDTH:      csr_prdata = 32'(cfg_ff.canvas_width);
         CSR_CANVAS_HEIGHT:     csr_prdata = 32'(cfg_ff.canvas_height);
         CSR_TRANSPARENCY_ON:   csr_prdata = 32'(cfg_ff.transparency_on);
         CSR_TRANSPARENT_INDEX: csr_prdata = 32'(cfg_ff.transparent_index);
         default:               csr_prdata = 32'd0;
      endcase
   end

   // Front end: takes beats, keeps the palette, places pixels and reads
   // their colour. Pixels that miss the sprite or are transparent stop here.
   ppitp_front #(
      .SPRITE_WIDTH  (SPRITE_WIDTH),
      .SPRITE_HEIGHT (SPRITE_HEIGHT),
      .MID_DEPTH     (MID_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .mid_count (mid_count),
      .mid_push  (mid_push),
      .mid_data  (mid_in_data)
   );

   // The front end reserves space before it accepts, so a push never meets
   // a full queue.
   ppitp_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // Back end: classifies the colour and queues the placement of ink.
   ppitp_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_out_data),
      .mid_pop   (mid_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
